// File: hw/rtl/plcm_pkg.sv
// Shared constants and types for the piecewise linear color map.
// Used by every design module of the block; depends on nothing else.

package plcm_pkg;

  // Fixed field widths.
  localparam int T_W       = 18;  // signed scalar input
  localparam int CNT_W     = 3;   // color count register
  localparam int COLOR_W   = 32;  // packed RGBA register
  localparam int CH_W      = 8;   // one color channel
  localparam int NUM_REGS  = 7;   // color registers present
  localparam int CFG_IDX_W = 3;   // configuration register index

  // Defaults for the top-level parameters.
  localparam int MAX_COLORS_DEF = 7;
  localparam int FRAC_BITS_DEF  = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_0 = 3'd1;

  localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

  // Per-item classification carried from the first to the second stage.
  typedef struct packed {
    logic                  gray;   // no colors in use: grey ramp of t
    logic                  fixed;  // one stored color, own alpha
    logic [CNT_W-1:0]      fidx;   // which stored color when fixed
  } ctl_t;

endpackage

// File: hw/rtl/plcm_front.sv
// First pipeline stage: classifies t against the color count and forms
// t*(n-1) and t*255. Depends on plcm_pkg.

module plcm_front #(
  parameter int MAX_COLORS = plcm_pkg::MAX_COLORS_DEF,
  parameter int FRAC_BITS  = plcm_pkg::FRAC_BITS_DEF,
  parameter int PW         = 20,
  parameter int GPW        = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [plcm_pkg::T_W-1:0]   t_value,
  input  logic [plcm_pkg::CNT_W-1:0]        color_count,
  output logic                              out_valid,
  input  logic                              out_ready,
  output plcm_pkg::ctl_t                    ctl,
  output logic [PW-1:0]                     pos,
  output logic [GPW-1:0]                    gprod
);

  localparam int MW = plcm_pkg::T_W - 1;
  localparam int CW = plcm_pkg::CNT_W;

  logic              t_pos;
  logic [MW-1:0]     mag;
  logic [CW-1:0]     n;
  logic [CW-1:0]     nm1;
  logic              ge_one;
  logic [MW+CW-1:0]  pos_prod;
  logic [MW+7:0]     gray_prod;
  plcm_pkg::ctl_t    ctl_next;
  logic              en;

  assign t_pos  = !t_value[plcm_pkg::T_W-1] && (|t_value[MW-1:0]);
  assign mag    = t_pos ? t_value[MW-1:0] : '0;
  assign n      = (color_count > CW'(MAX_COLORS)) ? CW'(MAX_COLORS) : color_count;
  assign nm1    = n - CW'(1);
  assign ge_one = PW'(mag) >= (PW'(1) << FRAC_BITS);

  assign pos_prod  = mag * nm1;
  assign gray_prod = mag * plcm_pkg::CH_MAX;

  always_comb begin
    ctl_next.gray  = (n == '0);
    ctl_next.fixed = (n == CW'(1)) || !t_pos || ge_one;
    ctl_next.fidx  = ((n == CW'(1)) || !t_pos) ? '0 : nm1;
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl   <= ctl_next;
      pos   <= PW'(pos_prod);
      gprod <= GPW'(gray_prod);
    end
  end

endmodule

// File: hw/rtl/plcm_select.sv
// Second pipeline stage: splits t*(n-1) into segment and weight, picks the
// left and right colors and finishes the grey ramp. Depends on plcm_pkg.

module plcm_select #(
  parameter int FRAC_BITS = plcm_pkg::FRAC_BITS_DEF,
  parameter int PW        = 20,
  parameter int GPW       = 25
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               in_valid,
  output logic                                               in_ready,
  input  plcm_pkg::ctl_t                                     ctl,
  input  logic [PW-1:0]                                      pos,
  input  logic [GPW-1:0]                                     gprod,
  input  logic [plcm_pkg::NUM_REGS-1:0][plcm_pkg::COLOR_W-1:0] colors,
  output logic                                               out_valid,
  input  logic                                               out_ready,
  output logic [plcm_pkg::COLOR_W-1:0]                       lc,
  output logic [plcm_pkg::COLOR_W-9:0]                       rc,
  output logic [FRAC_BITS-1:0]                               frac,
  output logic                                               keep_alpha
);

  localparam int CW = plcm_pkg::CNT_W;
  localparam int SW = ((GPW > FRAC_BITS) ? GPW : FRAC_BITS) + 1;

  logic [CW-1:0]                  lidx;
  logic [CW-1:0]                  ridx;
  logic [SW-1:0]                  gsum;
  logic [SW-1:0]                  gshift;
  logic [plcm_pkg::CH_W-1:0]      gval;
  logic [plcm_pkg::COLOR_W-1:0]   lc_next;
  logic [FRAC_BITS-1:0]           frac_next;
  logic                           en;

  assign lidx = ctl.fixed ? ctl.fidx : pos[FRAC_BITS +: CW];
  assign ridx = (lidx == CW'(plcm_pkg::NUM_REGS - 1)) ? '0 : lidx + CW'(1);

  // Grey ramp: round half up, then saturate to the channel range.
  assign gsum   = SW'(gprod) + (SW'(1) << (FRAC_BITS - 1));
  assign gshift = gsum >> FRAC_BITS;
  assign gval   = (gshift > SW'(plcm_pkg::CH_MAX)) ? plcm_pkg::CH_MAX
                                                   : gshift[plcm_pkg::CH_W-1:0];

  // A zero weight makes the blend return the left color unchanged, which
  // covers the fixed colors, exact knots and the grey ramp alike.
  assign lc_next   = ctl.gray ? {4{gval}} : colors[lidx];
  assign frac_next = (ctl.gray || ctl.fixed) ? '0 : pos[FRAC_BITS-1:0];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lc         <= lc_next;
      rc         <= colors[ridx][plcm_pkg::COLOR_W-1:8];
      frac       <= frac_next;
      keep_alpha <= ctl.gray || ctl.fixed;
    end
  end

endmodule

// File: hw/rtl/plcm_blend.sv
// Third pipeline stage: one signed multiply per RGB channel, registered,
// then the rounding add toward the left color. Depends on plcm_pkg.

module plcm_blend #(
  parameter int FRAC_BITS = plcm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [plcm_pkg::COLOR_W-1:0]   lc,
  input  logic [plcm_pkg::COLOR_W-9:0]   rc,
  input  logic [FRAC_BITS-1:0]           frac,
  input  logic                           keep_alpha,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [plcm_pkg::COLOR_W-1:0]   pixel
);

  localparam int CH = plcm_pkg::CH_W;
  localparam int PRW = CH + FRAC_BITS + 2;

  logic signed [PRW-1:0]          prod      [3];
  logic [plcm_pkg::COLOR_W-1:0]   lc_q;
  logic                           keep_q;
  logic                           en;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lc_q   <= lc;
      keep_q <= keep_alpha;
    end
  end

  // Channel k: red is k = 0 in the top byte.
  for (genvar k = 0; k < 3; k++) begin : g_ch
    logic signed [CH:0]     diff;
    logic signed [PRW-1:0]  rnd;
    logic signed [PRW-1:0]  step;

    assign diff = $signed({1'b0, rc[plcm_pkg::COLOR_W-9-CH*k -: CH]})
                - $signed({1'b0, lc[plcm_pkg::COLOR_W-1-CH*k -: CH]});

    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= diff * $signed({1'b0, frac});
      end
    end

    // L*(1-f) + R*f rounded equals L + round((R-L)*f); the sum stays in range.
    assign rnd  = prod[k] + (PRW'(1) << (FRAC_BITS - 1));
    assign step = rnd >>> FRAC_BITS;
    assign pixel[plcm_pkg::COLOR_W-1-CH*k -: CH] =
        lc_q[plcm_pkg::COLOR_W-1-CH*k -: CH] + step[CH-1:0];
  end

  assign pixel[CH-1:0] = keep_q ? lc_q[CH-1:0] : plcm_pkg::CH_MAX;

endmodule

// File: hw/rtl/piecewise_linear_colormap.sv
// Top level of the piecewise linear color map: configuration registers,
// the three work stages and the output register. Depends on plcm_pkg,
// plcm_front, plcm_select and plcm_blend.
//
//   Channel   Direction  Transaction carries
//   s_*       in         t_value, signed Q1.FRAC_BITS, tdata[17:0]
//   m_*       out        red [7:0], green [15:8], blue [23:16], alpha [31:24]
//   cfg_*     in         register write: color_count (0), color_0..color_6 (1..7)
//
// One transaction enters per clock while the output is not stalled; it passes
// through the classify, select and multiply stages and the output register.
// Every stage carries its own valid bit and moves whenever the stage after it
// is empty or moving, so bubbles close up and a stalled m_tready holds each
// item in place without loss or repetition. Reset is synchronous and clears
// the valid bits and all configuration registers (count 0, colors 0).
// Configuration is expected to change only while no item is in flight.

module piecewise_linear_colormap #(
  parameter int MAX_COLORS = plcm_pkg::MAX_COLORS_DEF,
  parameter int FRAC_BITS  = plcm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream. tdata: t_value [17:0], zero [23:18].
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,
  // Output stream. tdata: red [7:0], green [15:8], blue [23:16], alpha [31:24].
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,
  // Configuration write port.
  input  logic                               cfg_we,
  input  logic [plcm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plcm_pkg::COLOR_W-1:0]       cfg_data
);

  // Width of t*(n-1) wide enough to hold both the product and the segment
  // index above the fraction; width of the grey product t*255.
  localparam int PROD_W = plcm_pkg::T_W - 1 + plcm_pkg::CNT_W;
  localparam int PW     = (PROD_W > FRAC_BITS + plcm_pkg::CNT_W)
                          ? PROD_W : FRAC_BITS + plcm_pkg::CNT_W;
  localparam int GPW    = plcm_pkg::T_W - 1 + plcm_pkg::CH_W;
  localparam int CH     = plcm_pkg::CH_W;

  // Configuration registers.
  logic [plcm_pkg::CNT_W-1:0]                          color_count;
  logic [plcm_pkg::NUM_REGS-1:0][plcm_pkg::COLOR_W-1:0] colors;
  logic [plcm_pkg::CFG_IDX_W-1:0]                      color_sel;

  assign color_sel = cfg_index - plcm_pkg::REG_COLOR_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= '0;
      colors      <= '0;
    end else if (cfg_we) begin
      if (cfg_index == plcm_pkg::REG_COUNT) begin
        color_count <= cfg_data[plcm_pkg::CNT_W-1:0];
      end else begin
        colors[color_sel] <= cfg_data;
      end
    end
  end

  // Stage 1: classify t and form the products.
  logic            v1, r1;
  plcm_pkg::ctl_t  ctl1;
  logic [PW-1:0]   pos1;
  logic [GPW-1:0]  gprod1;

  plcm_front #(
    .MAX_COLORS (MAX_COLORS),
    .FRAC_BITS  (FRAC_BITS),
    .PW         (PW),
    .GPW        (GPW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .t_value     ($signed(s_tdata[plcm_pkg::T_W-1:0])),
    .color_count (color_count),
    .out_valid   (v1),
    .out_ready   (r1),
    .ctl         (ctl1),
    .pos         (pos1),
    .gprod       (gprod1)
  );

  // Stage 2: pick the segment colors and the weight.
  logic                          v2, r2;
  logic [plcm_pkg::COLOR_W-1:0]  lc2;
  logic [plcm_pkg::COLOR_W-9:0]  rc2;
  logic [FRAC_BITS-1:0]          frac2;
  logic                          keep2;

  plcm_select #(
    .FRAC_BITS (FRAC_BITS),
    .PW        (PW),
    .GPW       (GPW)
  ) u_select (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v1),
    .in_ready   (r1),
    .ctl        (ctl1),
    .pos        (pos1),
    .gprod      (gprod1),
    .colors     (colors),
    .out_valid  (v2),
    .out_ready  (r2),
    .lc         (lc2),
    .rc         (rc2),
    .frac       (frac2),
    .keep_alpha (keep2)
  );

  // Stage 3: per-channel multiply, rounding add on the way out.
  logic                          v3, r3;
  logic [plcm_pkg::COLOR_W-1:0]  pixel3;

  plcm_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v2),
    .in_ready   (r2),
    .lc         (lc2),
    .rc         (rc2),
    .frac       (frac2),
    .keep_alpha (keep2),
    .out_valid  (v3),
    .out_ready  (r3),
    .pixel      (pixel3)
  );

  // Output register. The pixel word has red on top; the stream puts red
  // in the low byte.
  logic en_out;

  assign en_out = !m_tvalid || m_tready;
  assign r3     = en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= {pixel3[CH-1:0], pixel3[2*CH-1:CH],
                  pixel3[3*CH-1:2*CH], pixel3[4*CH-1:3*CH]};
    end
  end

endmodule

// File: hw/rtl/plcm_checker.sv
// Port-level checks for the piecewise linear color map, attached to the
// top level by the bind statement at the end. Depends on nothing else.

module plcm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A ready sink lets every stage move, so the input is ready too.
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is ready");

  // With the sink ready, an accepted transaction reaches the output register valid.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind piecewise_linear_colormap plcm_checker u_plcm_checker (.*);
